>>> rtl/spmq_pkg.sv
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and constants for the shared pool multi queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

	localparam int NODE_COUNT  = 256;
	localparam int QUEUE_COUNT = 16;
	localparam int DATA_BITS   = 32;

	localparam int NODE_W   = $clog2(NODE_COUNT);
	localparam int CNT_W    = $clog2(NODE_COUNT + 1);
	localparam int QID_W    = 4;
	localparam int CFG_W    = 5;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	typedef logic [NODE_W-1:0]    node_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [QID_W-1:0]     qid_t;
	typedef logic [DATA_BITS-1:0] data_t;
	typedef logic [CFG_W-1:0]     cfg_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POOL_FULL = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_BAD_ID    = 2'd3
	} status_t;

	typedef enum logic {
		MODE_ENQ = 1'b0,
		MODE_DEQ = 1'b1
	} mode_t;

	// register index taken from paddr word bit
	localparam logic REG_QUEUES_IN_USE = 1'b0;
	localparam cfg_t QUEUES_RESET      = CFG_W'(QUEUE_COUNT);

	// controller to datapath commands
	typedef struct packed {
		logic capture;   // latch operation, issue pool reads
		logic commit;    // update pool and queue state, register result
	} cmd_t;

endpackage

>>> rtl/spmq_ctrl.sv
// ----------------------------------------------------------------------------
// spmq_ctrl
// Two-state sequencer: accept a word, then commit it in the next cycle.
// ----------------------------------------------------------------------------
module spmq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output spmq_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	assign busy        = (state_q == S_EXEC);
	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.commit  = (state_q == S_EXEC);
	assign done        = done_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.commit;
		end
	end

endmodule

>>> rtl/spmq_dp.sv
// ----------------------------------------------------------------------------
// spmq_dp
// Node pool, free stack, queue end pointers and lengths, result register.
// ----------------------------------------------------------------------------
module spmq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  spmq_pkg::cmd_t      cmd,
	input  logic                mode,
	input  spmq_pkg::qid_t      queue_id,
	input  spmq_pkg::data_t     data_in,
	input  spmq_pkg::cfg_t      queues_in_use,
	output logic [1:0]          res_status,
	output spmq_pkg::data_t     res_data,
	output spmq_pkg::cnt_t      res_count
);

	// pool memories, no reset
	spmq_pkg::node_t link_store [spmq_pkg::NODE_COUNT];
	spmq_pkg::data_t item_store [spmq_pkg::NODE_COUNT];

	// queue end pointers, no reset
	spmq_pkg::node_t oldest_q [spmq_pkg::QUEUE_COUNT];
	spmq_pkg::node_t newest_q [spmq_pkg::QUEUE_COUNT];

	spmq_pkg::cnt_t  qlen_q [spmq_pkg::QUEUE_COUNT];
	spmq_pkg::node_t free_top_q;
	spmq_pkg::cnt_t  never_used_q;
	spmq_pkg::cnt_t  nodes_used_q;

	// latched operation
	logic            mode_q;
	spmq_pkg::qid_t  qid_q;
	spmq_pkg::data_t data_q;

	spmq_pkg::node_t link_rd_q;
	spmq_pkg::data_t item_rd_q;
	spmq_pkg::node_t rd_addr;

	logic [1:0]      status_q;
	spmq_pkg::data_t data_out_q;
	spmq_pkg::cnt_t  count_q;

	spmq_pkg::cnt_t     len;
	logic               bad_id;
	logic               pool_full;
	logic               from_free;
	spmq_pkg::node_t    enq_node;
	spmq_pkg::node_t    deq_node;
	logic               do_enq;
	logic               do_deq;
	spmq_pkg::status_t  st;
	spmq_pkg::data_t    dout;
	spmq_pkg::cnt_t     cnt;
	logic               link_we;
	spmq_pkg::node_t    link_wa;
	spmq_pkg::node_t    link_wd;

	// pool read address: free stack top for an enqueue, oldest node for a dequeue
	assign rd_addr = (mode == spmq_pkg::MODE_ENQ) ? free_top_q : oldest_q[queue_id];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			link_rd_q <= link_store[rd_addr];
			item_rd_q <= item_store[rd_addr];
			mode_q    <= mode;
			qid_q     <= queue_id;
			data_q    <= data_in;
		end
	end

	assign len       = qlen_q[qid_q];
	assign bad_id    = (spmq_pkg::cfg_t'(qid_q) >= queues_in_use) ||
	                   (spmq_pkg::cfg_t'(qid_q) >= spmq_pkg::cfg_t'(spmq_pkg::QUEUE_COUNT));
	assign pool_full = (nodes_used_q == spmq_pkg::CNT_W'(spmq_pkg::NODE_COUNT));
	assign from_free = (nodes_used_q < never_used_q);
	assign enq_node  = from_free ? free_top_q : never_used_q[spmq_pkg::NODE_W-1:0];
	assign deq_node  = oldest_q[qid_q];

	always_comb begin
		st     = spmq_pkg::ST_OK;
		dout   = '0;
		cnt    = len;
		do_enq = 1'b0;
		do_deq = 1'b0;
		priority if (bad_id) begin
			st  = spmq_pkg::ST_BAD_ID;
			cnt = '0;
		end else if (mode_q == spmq_pkg::MODE_ENQ) begin
			if (pool_full) begin
				st = spmq_pkg::ST_POOL_FULL;
			end else begin
				do_enq = 1'b1;
				cnt    = len + spmq_pkg::CNT_W'(1);
			end
		end else if (len == '0) begin
			st  = spmq_pkg::ST_EMPTY;
			cnt = '0;
		end else begin
			do_deq = 1'b1;
			cnt    = len - spmq_pkg::CNT_W'(1);
			dout   = item_rd_q;
		end
	end

	// single link write port: chain behind the newest node, or push on free stack
	always_comb begin
		link_we = 1'b0;
		link_wa = deq_node;
		link_wd = free_top_q;
		if (do_enq) begin
			link_we = (len != '0);
			link_wa = newest_q[qid_q];
			link_wd = enq_node;
		end else if (do_deq) begin
			link_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && link_we) begin
			link_store[link_wa] <= link_wd;
		end
		if (cmd.commit && do_enq) begin
			item_store[enq_node] <= data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (do_enq) begin
				newest_q[qid_q] <= enq_node;
				if (len == '0) begin
					oldest_q[qid_q] <= enq_node;
				end
			end else if (do_deq && (cnt != '0)) begin
				oldest_q[qid_q] <= link_rd_q;
			end
			status_q   <= st;
			data_out_q <= dout;
			count_q    <= cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < spmq_pkg::QUEUE_COUNT; i++) begin
				qlen_q[i] <= '0;
			end
			free_top_q   <= '0;
			never_used_q <= '0;
			nodes_used_q <= '0;
		end else if (cmd.commit) begin
			if (do_enq) begin
				qlen_q[qid_q] <= cnt;
				nodes_used_q  <= nodes_used_q + spmq_pkg::CNT_W'(1);
				if (from_free) begin
					free_top_q <= link_rd_q;
				end else begin
					never_used_q <= never_used_q + spmq_pkg::CNT_W'(1);
				end
			end else if (do_deq) begin
				qlen_q[qid_q] <= cnt;
				nodes_used_q  <= nodes_used_q - spmq_pkg::CNT_W'(1);
				free_top_q    <= deq_node;
			end
		end
	end

	assign res_status = status_q;
	assign res_data   = data_out_q;
	assign res_count  = count_q;

endmodule

>>> rtl/shared_pool_multi_queue.sv
// ----------------------------------------------------------------------------
// shared_pool_multi_queue
// Sixteen FIFO queues sharing one pool of 256 linked nodes with a free stack.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive mode, queue_id and data_in with start high; the
//   word is taken at the edge where start is high and busy is low. Mode 0
//   enqueues data_in on queue_id, mode 1 dequeues its oldest word.
//   Result channel: done pulses for one cycle with status, data_out and
//   queue_count valid in that same cycle. The receiver cannot stall, so
//   results must be taken as they appear.
//   The result is registered as the word commits, while busy is high, and
//   is taken at the edge that follows.
//   Steps: accepting a word in the idle state reads the link and item
//   memories (one registered read port each); the exec state writes them
//   back and updates the queue pointers with busy high, so no new word is
//   taken until the one before it has committed.
//   APB port: register queues_in_use at address 0, written with psel,
//   penable and pwrite high; ids at or above it are rejected with status 3.
//   Write it only while the block is idle.
//   Reset: all queues empty, every node free, queues_in_use = 16. No memory
//   clearing pass is needed, so a command may be issued right after reset.
// ----------------------------------------------------------------------------
module shared_pool_multi_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [spmq_pkg::QID_W-1:0]    queue_id,
	input  logic [spmq_pkg::DATA_BITS-1:0] data_in,
	// result channel
	output logic                          done,
	output logic [1:0]                    status,
	output logic [spmq_pkg::DATA_BITS-1:0] data_out,
	output logic [spmq_pkg::CNT_W-1:0]    queue_count,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spmq_pkg::PADDR_W-1:0]  paddr,
	input  logic [spmq_pkg::PDATA_W-1:0]  pwdata,
	output logic [spmq_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	spmq_pkg::cmd_t cmd;
	spmq_pkg::cfg_t queues_q;
	logic           reg_sel;

	// configuration register: hold queues_in_use, written in the access phase
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == spmq_pkg::REG_QUEUES_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queues_q <= spmq_pkg::QUEUES_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			queues_q <= pwdata[spmq_pkg::CFG_W-1:0];
		end
	end

	// read back the register, zero elsewhere
	assign prdata = reg_sel ? spmq_pkg::PDATA_W'(queues_q) : '0;

	// sequencer: accept, then commit
	spmq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// pool, free stack and queue state
	spmq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.queue_id      (queue_id),
		.data_in       (data_in),
		.queues_in_use (queues_q),
		.res_status    (status),
		.res_data      (data_out),
		.res_count     (queue_count)
	);

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shared pool multi queue: predicts every
// enqueue and dequeue against its own copy of the node pool, free stack and
// queue chains, and compares each result word field by field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spmq_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int MAX_GAP       = 8;
	localparam int MAX_BURST     = 12;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_LIMIT   = 200;
	localparam int RUN_LIMIT_NS  = 5_000_000;

	// queues_in_use sits at byte address 0
	localparam logic [PADDR_W-1:0] ADDR_QUEUES_IN_USE = {REG_QUEUES_IN_USE, 2'b00};

	typedef struct {
		status_t status;
		data_t   word;
		cnt_t    count;
	} outcome_t;

	// Tracks the pool, the free stack and every queue chain, and holds the
	// outcomes still owed by the block in issue order.
	class pool_tracker;
		node_t    link_mem [NODE_COUNT];
		data_t    word_mem [NODE_COUNT];
		node_t    oldest [QUEUE_COUNT];
		node_t    newest [QUEUE_COUNT];
		cnt_t     length [QUEUE_COUNT];
		node_t    free_top;
		cnt_t     fresh_next;
		cnt_t     live_nodes;
		cfg_t     enabled;
		outcome_t awaited [$];
		int       mismatches;
		int       checked;
		int       tally [4];

		function new();
			foreach (length[i])
				length[i] = '0;
			foreach (tally[i])
				tally[i] = 0;
			free_top   = '0;
			fresh_next = '0;
			live_nodes = '0;
			enabled    = QUEUES_RESET;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void set_enabled(cfg_t v);
			enabled = v;
		endfunction

		// Work out the outcome of one accepted command word and advance state.
		function void note_command(mode_t m, qid_t q, data_t d);
			outcome_t r;
			node_t    n;
			r.status = ST_OK;
			r.word   = '0;
			r.count  = '0;
			if (int'(q) >= int'(enabled) || int'(q) >= QUEUE_COUNT) begin
				r.status = ST_BAD_ID;
			end else if (m == MODE_ENQ) begin
				if (int'(live_nodes) >= NODE_COUNT) begin
					r.status = ST_POOL_FULL;
					r.count  = length[q];
				end else begin
					// reuse a freed node first, else take the next fresh one
					if (live_nodes < fresh_next) begin
						n        = free_top;
						free_top = link_mem[n];
					end else begin
						n          = fresh_next[NODE_W-1:0];
						fresh_next = fresh_next + cnt_t'(1);
					end
					live_nodes  = live_nodes + cnt_t'(1);
					word_mem[n] = d;
					if (length[q] == '0)
						oldest[q] = n;
					else
						link_mem[newest[q]] = n;
					newest[q] = n;
					length[q] = length[q] + cnt_t'(1);
					r.count   = length[q];
				end
			end else begin
				if (length[q] == '0) begin
					r.status = ST_EMPTY;
				end else begin
					n         = oldest[q];
					r.word    = word_mem[n];
					length[q] = length[q] - cnt_t'(1);
					if (length[q] != '0)
						oldest[q] = link_mem[n];
					// push the node back on the free stack
					link_mem[n] = free_top;
					free_top    = n;
					live_nodes  = live_nodes - cnt_t'(1);
					r.count     = length[q];
				end
			end
			awaited.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, data_t w, cnt_t c);
			outcome_t e;
			if (awaited.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: status %0d word %h count %0d",
					$time, st, w, c);
				return;
			end
			e = awaited.pop_front();
			checked++;
			tally[e.status]++;
			if (st !== e.status) begin
				mismatches++;
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, e.status, st);
			end
			if (w !== e.word) begin
				mismatches++;
				$display("%0t: data_out mismatch: expected %h, actual %h",
					$time, e.word, w);
			end
			if (c !== e.count) begin
				mismatches++;
				$display("%0t: queue_count mismatch: expected %0d, actual %0d",
					$time, e.count, c);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                mode;
	logic [QID_W-1:0]    queue_id;
	data_t               data_in;
	logic                done;
	logic [1:0]          status;
	data_t               data_out;
	logic [CNT_W-1:0]    queue_count;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	pool_tracker tracker;
	int          burst_left;
	bit          gapless;
	int          words_sent;
	int          config_writes;

	shared_pool_multi_queue dut (.*);

	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Results cannot be held off: take every strobed word at the edge.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(status, data_out, queue_count);
	end

	// Issue one command word; drop start for a random gap between bursts.
	task automatic send_command(mode_t m, qid_t q, data_t d);
		int gap;
		if (!gapless && burst_left == 0) begin
			start <= 1'b0;
			gap = $urandom_range(MAX_GAP, 1);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(MAX_BURST, 1);
		end
		if (burst_left > 0)
			burst_left--;
		start    <= 1'b1;
		mode     <= m;
		queue_id <= q;
		data_in  <= d;
		// taken at the first edge with busy low
		do @(posedge clk); while (busy);
		tracker.note_command(m, q, d);
		words_sent++;
	endtask

	// Hold off until every awaited result has come back, then settle.
	task automatic idle_until_drained();
		int waited;
		start <= 1'b0;
		waited = 0;
		while (tracker.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drain, write queues_in_use over APB, then read it back.
	task automatic reconfigure(cfg_t v);
		logic [PDATA_W-1:0] readback;
		idle_until_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_QUEUES_IN_USE;
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_enabled(v);
		config_writes++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== PDATA_W'(v)) begin
			tracker.mismatches++;
			$display("%0t: queues_in_use readback mismatch: expected %h, actual %h",
				$time, PDATA_W'(v), readback);
		end
	endtask

	// Random phase: enq_pct steers the pool towards full or towards empty.
	task automatic run_random(int n, int enq_pct, bit no_gaps, cfg_t cfg);
		int    live_ids;
		mode_t m;
		qid_t  q;
		data_t d;
		reconfigure(cfg);
		gapless  = no_gaps;
		live_ids = (int'(cfg) > QUEUE_COUNT) ? QUEUE_COUNT : int'(cfg);
		repeat (n) begin
			m = (int'($urandom_range(99)) < enq_pct) ? MODE_ENQ : MODE_DEQ;
			// mostly enabled queues, now and then any id
			if (live_ids > 0 && $urandom_range(99) < 85)
				q = qid_t'($urandom_range(live_ids - 1));
			else
				q = qid_t'($urandom_range(QUEUE_COUNT - 1));
			case ($urandom_range(15))
				0:       d = '0;
				1:       d = '1;
				2:       d = data_t'(1) << $urandom_range(DATA_BITS - 1);
				default: d = data_t'($urandom);
			endcase
			send_command(m, q, d);
		end
	endtask

	initial begin
		tracker       = new();
		burst_left    = 0;
		gapless       = 1'b0;
		words_sent    = 0;
		config_writes = 0;
		arst_n   = 1'b0;
		start    <= 1'b0;
		mode     <= MODE_ENQ;
		queue_id <= '0;
		data_in  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty and extreme words, then disabled queues keep their nodes.
		reconfigure(QUEUES_RESET);
		send_command(MODE_DEQ, 4'd0, '0);
		send_command(MODE_ENQ, 4'd0, '0);
		send_command(MODE_ENQ, 4'd0, '1);
		send_command(MODE_ENQ, 4'd15, 32'hA5A5_A5A5);
		send_command(MODE_ENQ, 4'd3, 32'h5A5A_5A5A);
		send_command(MODE_DEQ, 4'd0, 32'hFFFF_0000);
		send_command(MODE_DEQ, 4'd0, '0);
		send_command(MODE_DEQ, 4'd0, '0);
		send_command(MODE_ENQ, 4'd15, 32'h8000_0001);
		// one queue left enabled: queues 3 and 15 now rejected
		reconfigure(cfg_t'(1));
		send_command(MODE_ENQ, 4'd3, 32'h1111_1111);
		send_command(MODE_DEQ, 4'd15, '0);
		send_command(MODE_ENQ, 4'd0, 32'h1234_5678);
		send_command(MODE_DEQ, 4'd0, '0);
		// zero rejects every id
		reconfigure(cfg_t'(0));
		send_command(MODE_ENQ, 4'd0, 32'h0F0F_0F0F);
		send_command(MODE_DEQ, 4'd0, '0);
		// above the queue count acts as all sixteen; the old words return
		reconfigure(cfg_t'(31));
		send_command(MODE_DEQ, 4'd15, '0);
		send_command(MODE_DEQ, 4'd15, '0);
		send_command(MODE_DEQ, 4'd3, '0);
		send_command(MODE_DEQ, 4'd3, '0);
		send_command(MODE_ENQ, 4'd15, 32'h0000_FFFF);

		// Random: mixed, single queue, fill past full, drain, then odd settings.
		run_random(150, 55, 1'b0, QUEUES_RESET);
		run_random(80, 50, 1'b1, cfg_t'(1));
		run_random(330, 95, 1'b0, QUEUES_RESET);
		run_random(200, 20, 1'b0, cfg_t'($urandom_range(15, 2)));
		run_random(150, 50, 1'b1, cfg_t'(31));
		run_random(30, 50, 1'b0, cfg_t'(0));
		run_random(150, 15, 1'b0, QUEUES_RESET);
		idle_until_drained();

		$display("Issued %0d command words over %0d register writes; %0d results checked.",
			words_sent, config_writes, tracker.checked);
		$display("Outcomes: ok %0d, pool full %0d, queue empty %0d, bad id %0d.",
			tracker.tally[ST_OK], tracker.tally[ST_POOL_FULL],
			tracker.tally[ST_EMPTY], tracker.tally[ST_BAD_ID]);
		if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout after %0d ns", RUN_LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/spmq_pkg.sv
rtl/spmq_ctrl.sv
rtl/spmq_dp.sv
rtl/shared_pool_multi_queue.sv
tb/tb.sv
